// File: hw/rtl/vdfm_pkg.sv
// Package: shared constants and types of the loop detector fault monitor.
package vdfm_pkg;
	localparam int unsigned StoreDepth = 256;
	localparam int unsigned AddrW = $clog2(StoreDepth);
	localparam int unsigned CntW = AddrW + 1;
	localparam int unsigned SecPerMin = 60;

	typedef enum logic [1:0] {
		ACT_ENTER = 2'd0,
		ACT_LEAVE = 2'd1,
		ACT_CHECK = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_NO_RESP  = 2'd0,
		CFG_MAX_PRES = 2'd1,
		CFG_MAX_VEH  = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] FaultNone = 2'd0;
	localparam logic [1:0] FaultNoResp = 2'd1;
	localparam logic [1:0] FaultMaxPres = 2'd2;
	localparam logic [1:0] FaultCount = 2'd3;
	localparam logic [2:0] EvClearBase = 3'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDROP,
		ST_ESCAN,
		ST_ESHIFT,
		ST_LSCAN,
		ST_LREMOVE,
		ST_XDROP,
		ST_XSCAN,
		ST_XSHIFT,
		ST_CSCAN_E,
		ST_CSCAN_X,
		ST_CDONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       detector_ok;
		logic [1:0] fault_state;
		logic [2:0] report_event;
	} result_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_seconds;
	} item_t;
endpackage

// File: hw/rtl/vdfm_if.sv
// Interfaces: valid/ready channels for input items and results.
interface vdfm_in_if import vdfm_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] now_seconds;
	modport source (output valid, action, now_seconds, input ready);
	modport sink (input valid, action, now_seconds, output ready);
endinterface

interface vdfm_out_if import vdfm_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       detector_ok;
	logic [1:0] fault_state;
	logic [2:0] report_event;
	modport source (output valid, detector_ok, fault_state, report_event, input ready);
	modport sink (input valid, detector_ok, fault_state, report_event, output ready);
endinterface

// File: hw/rtl/vehicle_detector_fault_monitor.sv
// Top level: loop detector fault monitor with enter and leave stores in RAM.
//
// Usage
//   item channel: one beat per event (action enter, leave or check, with the
//   time in seconds). Action 3 is absorbed and ignored.
//   result channel: one beat per check only (detector_ok, fault_state and
//   report_event); enter and leave give no beat.
//   cfg port: write enable, index 0..2, 8-bit data; write only while idle.
// Sequencing
//   One item in flight at a time; the sequencer walks the stores entry by
//   entry, issuing a read and then acting on the registered read data,
//   through RAMs with one read and one write port. An enter scans the
//   enter store; a leave scans it, also dropping each later open entry it
//   meets, then scans the leave store; a check walks both stores before
//   the result register. A full store adds a one-off compaction first.
// Reset
//   arst_n clears state, counts, status, start latch, config and valid
//   flags; store contents are undefined and only entries below the fill
//   counts are ever read, so no clearing pass is needed.
// Stall
//   A finished result is held in an output register until taken; the next
//   item is accepted meanwhile, and its own result waits until that register
//   is free again.
module vehicle_detector_fault_monitor
	import vdfm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	vdfm_in_if.sink       item,
	vdfm_out_if.source    result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	// enter store: time, duration (unused downstream but kept), open bit
	logic [31:0] etime_mem [StoreDepth];
	logic [31:0] edur_mem [StoreDepth];
	logic        eopen_mem [StoreDepth];
	logic [31:0] xtime_mem [StoreDepth];
	logic [31:0] xdur_mem [StoreDepth];

	state_t state_q, state_d;
	logic [CntW-1:0] ecnt_q, xcnt_q;
	logic [1:0] status_q;
	logic [31:0] start_q;
	logic start_vld_q;
	logic [7:0] nr_min_q, mp_min_q, mv_min_q;
	item_t it_q;
	logic [CntW-1:0] idx_q;       // read address walk
	logic [CntW-1:0] pos_q;       // insert/remove position
	logic rd_vld_q;               // read data valid this cycle
	logic [31:0] et_rd, ed_rd, xt_rd, xd_rd;
	logic eo_rd;
	logic [31:0] carry_t_q, carry_d_q; // shifting carries
	logic carry_o_q;
	logic [31:0] dur_q;
	logic hit_nr_q, hit_mp_q;
	logic [8:0] vcnt_q;
	logic [33:0] nr_sec_q, mp_sec_q;
	result_t res_q;
	logic res_vld_q;

	// read ports (registered data)
	logic [AddrW-1:0] ra;
	logic             e_we, x_we;
	logic [AddrW-1:0] e_wa, x_wa;
	logic [31:0] e_wt, e_wd, x_wt, x_wd;
	logic e_wo;

	assign ra = idx_q[AddrW-1:0];
	always_ff @(posedge clk) begin
		et_rd <= etime_mem[ra];
		ed_rd <= edur_mem[ra];
		eo_rd <= eopen_mem[ra];
		xt_rd <= xtime_mem[ra];
		xd_rd <= xdur_mem[ra];
		if (e_we) begin
			etime_mem[e_wa] <= e_wt;
			edur_mem[e_wa]  <= e_wd;
			eopen_mem[e_wa] <= e_wo;
		end
		if (x_we) begin
			xtime_mem[x_wa] <= x_wt;
			xdur_mem[x_wa]  <= x_wd;
		end
	end

	localparam logic [CntW-1:0] Half = CntW'(StoreDepth / 2);
	localparam logic [CntW-1:0] Full = CntW'(StoreDepth);

	logic [31:0] now;
	assign now = it_q.now_seconds;

	// window helper: lower bound now-sec in 34-bit signed
	function automatic logic in_win(input logic [31:0] x, input logic [31:0] n,
			input logic [33:0] sec);
		logic signed [33:0] lo;
		lo = $signed({2'b00, n}) - $signed(sec);
		return ($signed({2'b00, x}) >= lo) && (x < n);
	endfunction

	function automatic logic win_ok(input logic [31:0] n, input logic [33:0] sec,
			input logic [31:0] st, input logic [1:0] status, input logic [1:0] own);
		logic signed [33:0] lo;
		lo = $signed({2'b00, n}) - $signed(sec);
		return (status == own || status == FaultNone) && (lo > $signed({2'b00, st}));
	endfunction

	logic accept;
	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign result.valid = res_vld_q;
	assign result.detector_ok = res_q.detector_ok;
	assign result.fault_state = res_q.fault_state;
	assign result.report_event = res_q.report_event;

	logic rd_cur; // read data was fetched last cycle from idx_q (from idx_q-1 in the drop states)
	logic [CntW-1:0] idx_d, pos_d, ecnt_d, xcnt_d;
	logic rd_vld_d;
	logic [31:0] carry_t_d, carry_d_d, dur_d;
	logic carry_o_d, hit_nr_d, hit_mp_d;
	logic [8:0] vcnt_d;
	logic [1:0] status_d;
	logic res_load;
	result_t res_d;

	assign rd_cur = rd_vld_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pos_d = pos_q;
		ecnt_d = ecnt_q;
		xcnt_d = xcnt_q;
		rd_vld_d = 1'b0;
		carry_t_d = carry_t_q;
		carry_d_d = carry_d_q;
		carry_o_d = carry_o_q;
		dur_d = dur_q;
		hit_nr_d = hit_nr_q;
		hit_mp_d = hit_mp_q;
		vcnt_d = vcnt_q;
		status_d = status_q;
		res_load = 1'b0;
		res_d = res_q;
		e_we = 1'b0; e_wa = '0; e_wt = '0; e_wd = '0; e_wo = 1'b0;
		x_we = 1'b0; x_wa = '0; x_wt = '0; x_wd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d = '0;
					pos_d = '0;
					rd_vld_d = 1'b0;
					unique case (action_t'(item.action))
						ACT_ENTER: begin
							state_d = (ecnt_q >= Full) ? ST_EDROP : ST_ESCAN;
							if (ecnt_q >= Full) idx_d = Half;
						end
						ACT_LEAVE: state_d = ST_LSCAN;
						ACT_CHECK: begin
							state_d = ST_CSCAN_E;
							hit_nr_d = 1'b0;
							hit_mp_d = 1'b0;
							vcnt_d = '0;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			// compaction: stream entries Half and up down to 0, one per cycle
			ST_EDROP: begin
				if (rd_cur) begin
					e_we = 1'b1; e_wa = pos_q[AddrW-1:0];
					e_wt = et_rd; e_wd = ed_rd; e_wo = eo_rd;
					pos_d = pos_q + 1'b1;
				end
				if (idx_q < ecnt_q) begin
					idx_d = idx_q + 1'b1;
					rd_vld_d = 1'b1;
				end else begin
					ecnt_d = ecnt_q - Half;
					idx_d = '0; pos_d = '0;
					state_d = ST_ESCAN;
				end
			end
			// find first entry with time > now, then shift tail up by one
			ST_ESCAN: begin
				if (!rd_cur) begin
					if (idx_q >= ecnt_q) begin
						e_we = 1'b1; e_wa = ecnt_q[AddrW-1:0];
						e_wt = now; e_wd = '0; e_wo = 1'b1;
						ecnt_d = ecnt_q + 1'b1;
						state_d = ST_IDLE;
					end else rd_vld_d = 1'b1;
				end else if (et_rd > now) begin
					// insert here; displaced entry becomes the carry
					e_we = 1'b1; e_wa = idx_q[AddrW-1:0];
					e_wt = now; e_wd = '0; e_wo = 1'b1;
					carry_t_d = et_rd; carry_d_d = ed_rd; carry_o_d = eo_rd;
					idx_d = idx_q + 1'b1;
					state_d = ST_ESHIFT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_ESHIFT: begin
				if (idx_q >= ecnt_q) begin
					e_we = 1'b1; e_wa = idx_q[AddrW-1:0];
					e_wt = carry_t_q; e_wd = carry_d_q; e_wo = carry_o_q;
					ecnt_d = ecnt_q + 1'b1;
					state_d = ST_IDLE;
				end else if (!rd_cur) begin
					rd_vld_d = 1'b1;
				end else begin
					e_we = 1'b1; e_wa = idx_q[AddrW-1:0];
					e_wt = carry_t_q; e_wd = carry_d_q; e_wo = carry_o_q;
					carry_t_d = et_rd; carry_d_d = ed_rd; carry_o_d = eo_rd;
					idx_d = idx_q + 1'b1;
				end
			end
			// leave: find oldest open entry, dropping later open ones
			ST_LSCAN: begin
				dur_d = dur_q;
				if (!rd_cur) begin
					if (idx_q >= ecnt_q) begin
						dur_d = '0;
						idx_d = (xcnt_q >= Full) ? Half : '0;
						state_d = (xcnt_q >= Full) ? ST_XDROP : ST_XSCAN;
					end else rd_vld_d = 1'b1;
				end else if (eo_rd && now < et_rd) begin
					pos_d = idx_q;
					idx_d = idx_q + 1'b1;
					state_d = ST_LREMOVE;
				end else if (eo_rd) begin
					e_we = 1'b1; e_wa = idx_q[AddrW-1:0];
					e_wt = et_rd; e_wd = now - et_rd; e_wo = 1'b0;
					dur_d = now - et_rd;
					idx_d = (xcnt_q >= Full) ? Half : '0;
					state_d = (xcnt_q >= Full) ? ST_XDROP : ST_XSCAN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			// shift entries above pos down by one, then resume scan at pos
			ST_LREMOVE: begin
				if (idx_q >= ecnt_q) begin
					ecnt_d = ecnt_q - 1'b1;
					idx_d = pos_q;
					state_d = ST_LSCAN;
				end else if (!rd_cur) begin
					rd_vld_d = 1'b1;
				end else begin
					e_we = 1'b1; e_wa = AddrW'(idx_q - 1'b1);
					e_wt = et_rd; e_wd = ed_rd; e_wo = eo_rd;
					idx_d = idx_q + 1'b1;
				end
			end
			ST_XDROP: begin
				if (rd_cur) begin
					x_we = 1'b1; x_wa = pos_q[AddrW-1:0];
					x_wt = xt_rd; x_wd = xd_rd;
					pos_d = pos_q + 1'b1;
				end
				if (idx_q < xcnt_q) begin
					idx_d = idx_q + 1'b1;
					rd_vld_d = 1'b1;
				end else begin
					xcnt_d = xcnt_q - Half;
					idx_d = '0; pos_d = '0;
					state_d = ST_XSCAN;
				end
			end
			ST_XSCAN: begin
				if (!rd_cur) begin
					if (idx_q >= xcnt_q) begin
						x_we = 1'b1; x_wa = xcnt_q[AddrW-1:0];
						x_wt = now; x_wd = dur_q;
						xcnt_d = xcnt_q + 1'b1;
						state_d = ST_IDLE;
					end else rd_vld_d = 1'b1;
				end else if (xt_rd > now) begin
					x_we = 1'b1; x_wa = idx_q[AddrW-1:0];
					x_wt = now; x_wd = dur_q;
					carry_t_d = xt_rd; carry_d_d = xd_rd;
					idx_d = idx_q + 1'b1;
					state_d = ST_XSHIFT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_XSHIFT: begin
				if (idx_q >= xcnt_q) begin
					x_we = 1'b1; x_wa = idx_q[AddrW-1:0];
					x_wt = carry_t_q; x_wd = carry_d_q;
					xcnt_d = xcnt_q + 1'b1;
					state_d = ST_IDLE;
				end else if (!rd_cur) begin
					rd_vld_d = 1'b1;
				end else begin
					x_we = 1'b1; x_wa = idx_q[AddrW-1:0];
					x_wt = carry_t_q; x_wd = carry_d_q;
					carry_t_d = xt_rd; carry_d_d = xd_rd;
					idx_d = idx_q + 1'b1;
				end
			end
			// check: walk enter store for no-response, then leave store
			ST_CSCAN_E: begin
				if (!rd_cur) begin
					if (idx_q >= ecnt_q) begin
						idx_d = '0;
						state_d = ST_CSCAN_X;
					end else rd_vld_d = 1'b1;
				end else begin
					if (in_win(et_rd, now, nr_sec_q)) hit_nr_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CSCAN_X: begin
				if (!rd_cur) begin
					if (idx_q >= xcnt_q) state_d = ST_CDONE;
					else rd_vld_d = 1'b1;
				end else begin
					if (in_win(xt_rd, now, mp_sec_q) && {2'b00, xd_rd} > mp_sec_q)
						hit_mp_d = 1'b1;
					if (in_win(xt_rd, now, 34'(SecPerMin)))
						vcnt_d = vcnt_q + 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CDONE: begin
				logic f_nr, f_mp, f_vc;
				logic [1:0] fault;
				f_nr = (nr_min_q != '0) && win_ok(now, nr_sec_q, start_q, status_q, FaultNoResp)
					&& !hit_nr_q;
				f_mp = (mp_min_q != '0) && win_ok(now, mp_sec_q, start_q, status_q, FaultMaxPres)
					&& hit_mp_q;
				f_vc = (mv_min_q != '0)
					&& win_ok(now, 34'(SecPerMin), start_q, status_q, FaultCount)
					&& (vcnt_q > {1'b0, mv_min_q});
				fault = f_nr ? FaultNoResp : f_mp ? FaultMaxPres : f_vc ? FaultCount : FaultNone;
				res_d.report_event = 3'd0;
				res_d.detector_ok = (fault == FaultNone);
				if (fault != FaultNone) begin
					if (status_q == FaultNone) begin
						status_d = fault;
						res_d.report_event = {1'b0, fault};
					end
				end else if (status_q != FaultNone) begin
					res_d.report_event = {1'b0, status_q} + EvClearBase;
					status_d = FaultNone;
				end
				res_d.fault_state = status_d;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_vld_q || result.ready) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end
				res_d = res_q;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result of CDONE parked in pend_q; ST_OUT moves it into the output register res_q
	result_t pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ecnt_q <= '0;
			xcnt_q <= '0;
			status_q <= FaultNone;
			start_q <= '0;
			start_vld_q <= 1'b0;
			nr_min_q <= '0;
			mp_min_q <= '0;
			mv_min_q <= '0;
			rd_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ecnt_q <= ecnt_d;
			xcnt_q <= xcnt_d;
			status_q <= status_d;
			rd_vld_q <= rd_vld_d;
			if (accept && item.action != ACT_NONE && !start_vld_q) begin
				start_q <= item.now_seconds;
				start_vld_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NO_RESP:  nr_min_q <= cfg_data;
					CFG_MAX_PRES: mp_min_q <= cfg_data;
					CFG_MAX_VEH:  mv_min_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) res_vld_q <= 1'b1;
			else if (result.ready) res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) it_q <= '{action: item.action, now_seconds: item.now_seconds};
		idx_q <= idx_d;
		pos_q <= pos_d;
		carry_t_q <= carry_t_d;
		carry_d_q <= carry_d_d;
		carry_o_q <= carry_o_d;
		dur_q <= dur_d;
		hit_nr_q <= hit_nr_d;
		hit_mp_q <= hit_mp_d;
		vcnt_q <= vcnt_d;
		nr_sec_q <= 34'(nr_min_q) * 34'(SecPerMin);
		mp_sec_q <= 34'(mp_min_q) * 34'(SecPerMin);
		if (state_q == ST_CDONE) pend_q <= res_d;
		if (res_load) res_q <= pend_q;
	end

	// fill counts never exceed the depth
	a_ecnt: assert property (@(posedge clk) disable iff (!arst_n) ecnt_q <= Full)
		else $error("enter count overflow");
	a_xcnt: assert property (@(posedge clk) disable iff (!arst_n) xcnt_q <= Full)
		else $error("leave count overflow");
	// a result beat only leaves after a check walk
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> $past(state_q == ST_CDONE) || $past(state_q == ST_OUT))
		else $error("result without check");
	// nothing accepted while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !item.ready)
		else $error("accept while busy");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> $past(state_q != ST_IDLE))
		else $error("stray read");
endmodule
